// ----- design/msc_pkg.sv -----
// Shared types and constants for the marquee scroll controller.
// No dependencies; every other file imports this package.
package msc_pkg;

  // Fixed field widths
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int STEP_W     = 4;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Request opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PIXELS   = 3'd4;

  // Configuration reset values
  localparam int               RST_VISIBLE_WIDTH = 196;
  localparam logic [MS_W-1:0]   RST_START_HOLD    = 16'd900;
  localparam logic [MS_W-1:0]   RST_END_HOLD      = 16'd1200;
  localparam logic [MS_W-1:0]   RST_STEP_INTERVAL = 16'd50;
  localparam logic [STEP_W-1:0] RST_STEP_PIXELS   = 4'd1;

  // Scroll phase as reported in the result
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SCROLL = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
    logic mul;
    logic commit_simple;
    logic commit_step;
    logic emit;
  } msc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } msc_stat_t;

endpackage

// ----- design/msc_channels.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on msc_pkg for the fixed field widths.
interface msc_in_if
  import msc_pkg::*;
#(
  parameter int PIXEL_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [TIME_W-1:0]     now_ms;
  logic [PIXEL_BITS-1:0] content_width;

  modport source (output valid, op, now_ms, content_width, input ready);
  modport sink   (input valid, op, now_ms, content_width, output ready);
endinterface

interface msc_out_if
  import msc_pkg::*;
#(
  parameter int PIXEL_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  redraw;
  logic [PIXEL_BITS-1:0] offset_px;
  logic [PHASE_W-1:0]    phase;

  modport source (output valid, redraw, offset_px, phase, input ready);
  modport sink   (input valid, redraw, offset_px, phase, output ready);
endinterface

// ----- design/marquee_scroll_controller_unit.sv -----
// Marquee scroll controller: one result per request. A restart, or a tick
// that does not advance the scroll, goes through evaluate and emit; a
// scrolling tick with at least one whole step interval elapsed also runs
// the restoring divider that counts whole step intervals, then multiply
// and step. A finished result waits in an output register, so the next
// request is taken while it is still pending.
// Depends on msc_pkg, msc_channels, msc_ctrl and msc_datapath.
module marquee_scroll_controller_unit
  import msc_pkg::*;
#(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msc_in_if.sink                item,
  msc_out_if.source             result
);
  msc_cmd_t  cmd;
  msc_stat_t stat;
  logic      in_ready;

  assign item.ready = in_ready;

  msc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (item.valid && in_ready),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  msc_datapath #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (item.op),
    .in_now_ms       (item.now_ms),
    .in_content_width(item.content_width),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_redraw      (result.redraw),
    .out_offset_px   (result.offset_px),
    .out_phase       (result.phase)
  );

endmodule

// ----- design/msc_divider.sv -----
// Restoring divider, one quotient bit per cycle, for elapsed time over step interval.
// Depends on msc_pkg.
module msc_divider
  import msc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [MS_W-1:0]   divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient,
  output logic [MS_W-1:0]   remainder
);
  localparam int CNT_W = $clog2(TIME_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MS_W-1:0]  dvs;
  logic [MS_W:0]    shifted;
  logic [MS_W:0]    trial;
  logic             fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {remainder, quotient[TIME_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in, keep the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[TIME_W-2:0], fits};
      remainder <= fits ? trial[MS_W-1:0] : shifted[MS_W-1:0];
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> remainder < dvs)
    else $error("divider remainder not below divisor");

endmodule

// ----- design/msc_datapath.sv -----
// Datapath: configuration registers, scroll state, step arithmetic and result register.
// Depends on msc_pkg and msc_divider.
module msc_datapath
  import msc_pkg::*;
#(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_op,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic [PIXEL_BITS-1:0] in_content_width,
  input  msc_cmd_t              cmd,
  output msc_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_redraw,
  output logic [PIXEL_BITS-1:0] out_offset_px,
  output logic [PHASE_W-1:0]    out_phase
);
  localparam int PROD_W = TIME_W + STEP_W;
  localparam int SUM_W  = PROD_W + 1;

  // Configuration
  logic [PIXEL_BITS-1:0] visible_width;
  logic [MS_W-1:0]       start_hold_ms;
  logic [MS_W-1:0]       end_hold_ms;
  logic [MS_W-1:0]       step_interval_ms;
  logic [STEP_W-1:0]     step_pixels;

  // Latched request
  logic                  req_op;
  logic [TIME_W-1:0]     req_now;
  logic [PIXEL_BITS-1:0] req_width;

  // Scroll state
  phase_t                scroll_phase;
  logic [TIME_W-1:0]     phase_start_time;
  logic [TIME_W-1:0]     last_step_time;
  logic [PIXEL_BITS-1:0] scroll_offset;
  logic [PIXEL_BITS-1:0] scroll_distance;
  logic                  pend_redraw;

  // Step arithmetic
  logic [MS_W-1:0]       ivl;
  logic [TIME_W-1:0]     elapsed_step;
  logic [TIME_W-1:0]     elapsed_phase;
  logic                  lead_over;
  logic                  trail_over;
  logic                  div_done;
  logic [TIME_W-1:0]     quotient;
  logic [MS_W-1:0]       remainder;
  logic [PROD_W-1:0]     advance;
  logic [SUM_W-1:0]      sum;
  logic [PIXEL_BITS-1:0] offset_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      visible_width    <= PIXEL_BITS'(RST_VISIBLE_WIDTH);
      start_hold_ms    <= RST_START_HOLD;
      end_hold_ms      <= RST_END_HOLD;
      step_interval_ms <= RST_STEP_INTERVAL;
      step_pixels      <= RST_STEP_PIXELS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VISIBLE_WIDTH: visible_width    <= cfg_data[PIXEL_BITS-1:0];
        CFG_START_HOLD:    start_hold_ms    <= cfg_data[MS_W-1:0];
        CFG_END_HOLD:      end_hold_ms      <= cfg_data[MS_W-1:0];
        CFG_STEP_INTERVAL: step_interval_ms <= cfg_data[MS_W-1:0];
        CFG_STEP_PIXELS:   step_pixels      <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= in_op;
      req_now   <= in_now_ms;
      req_width <= in_content_width;
    end
  end

  // Elapsed times, wrapping modulo 2^32
  assign ivl           = (step_interval_ms == '0) ? MS_W'(1) : step_interval_ms;
  assign elapsed_step  = req_now - last_step_time;
  assign elapsed_phase = req_now - phase_start_time;
  assign lead_over     = elapsed_phase >= TIME_W'(start_hold_ms);
  assign trail_over    = elapsed_phase >= TIME_W'(end_hold_ms);

  assign stat.need_div = (req_op == OP_TICK) && (scroll_distance != '0) &&
                         (scroll_phase == PH_SCROLL) && (elapsed_step >= TIME_W'(ivl));
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

  msc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (elapsed_step),
    .divisor  (ivl),
    .done     (div_done),
    .quotient (quotient),
    .remainder(remainder)
  );

  // Register the pixel advance: whole steps times step size
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      advance <= quotient * PROD_W'(step_pixels);
    end
  end

  // Saturate the new offset at the overflow distance
  assign sum         = SUM_W'(scroll_offset) + SUM_W'(advance);
  assign offset_next = (sum > SUM_W'(scroll_distance)) ? scroll_distance
                                                      : sum[PIXEL_BITS-1:0];

  // Update the scroll state
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_phase     <= PH_IDLE;
      phase_start_time <= '0;
      last_step_time   <= '0;
      scroll_offset    <= '0;
      scroll_distance  <= '0;
      pend_redraw      <= 1'b0;
    end else if (cmd.commit_simple) begin
      pend_redraw <= 1'b0;
      if (req_op == OP_RESTART) begin
        phase_start_time <= req_now;
        last_step_time   <= req_now;
        scroll_offset    <= '0;
        pend_redraw      <= 1'b1;
        if (req_width > visible_width) begin
          scroll_distance <= req_width - visible_width;
          scroll_phase    <= PH_LEAD;
        end else begin
          scroll_distance <= '0;
          scroll_phase    <= PH_IDLE;
        end
      end else if (scroll_distance != '0) begin
        if (scroll_phase == PH_LEAD && lead_over) begin
          scroll_phase   <= PH_SCROLL;
          last_step_time <= req_now;
        end else if (scroll_phase == PH_TRAIL && trail_over) begin
          scroll_offset    <= '0;
          scroll_phase     <= PH_LEAD;
          phase_start_time <= req_now;
          last_step_time   <= req_now;
          pend_redraw      <= 1'b1;
        end
      end
    end else if (cmd.commit_step) begin
      // Whole steps times interval equals elapsed minus the remainder
      last_step_time <= req_now - TIME_W'(remainder);
      scroll_offset  <= offset_next;
      pend_redraw    <= offset_next != scroll_offset;
      if (offset_next >= scroll_distance) begin
        scroll_phase     <= PH_TRAIL;
        phase_start_time <= req_now;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_redraw    <= pend_redraw;
      out_offset_px <= scroll_offset;
      out_phase     <= scroll_phase;
    end
  end

  a_offset_bounded: assert property (@(posedge clk) disable iff (rst)
    scroll_offset <= scroll_distance)
    else $error("offset beyond scroll distance");

  a_idle_at_zero: assert property (@(posedge clk) disable iff (rst)
    scroll_phase == PH_IDLE |-> scroll_offset == '0)
    else $error("nonzero offset while idle");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result overwritten before it was taken");

endmodule

// ----- design/msc_ctrl.sv -----
// Controller state machine: sequences accept, evaluate, divide, multiply, step and emit.
// Depends on msc_pkg.
module msc_ctrl
  import msc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  output logic      in_ready,
  input  msc_stat_t stat,
  output msc_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_STEP = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take a request only while waiting for one
  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.commit_simple = 1'b1;
          state_next        = S_EMIT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.commit_step = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
